[rtl/core/chbd_pkg.sv]
package chbd_pkg;

  // Decoder phase within one chunked body.
  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  // What a result item carries.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_TOO_LARGE = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_e;

  // Narrow decoder control state.
  typedef struct packed {
    phase_e     phase;
    logic       digits_stopped;
    logic       cr_seen;
    logic [1:0] skip_count;
  } ctrl_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_MAX_BODY_SIZE = 1'b0,
    REG_NONE          = 1'b1
  } reg_e;

  localparam logic [7:0]  ChrCr           = 8'h0D;
  localparam logic [7:0]  ChrLf           = 8'h0A;
  localparam logic [1:0]  TrailerLen      = 2'd2;
  localparam logic [31:0] MaxBodySizeRst  = 32'd1048576;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Converts an ASCII byte to a hex digit value.
  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h41 + 8'd10);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

[rtl/core/http_chunked_body_decoder_top.sv]
// Chunked HTTP body decoder. Raw body bytes enter on the slave stream, one
// byte per request, with tuser set on the first byte of each new body; the
// master stream carries decoded body bytes and status items (complete, body
// too large, size overflow) whose kind travels in tuser. The block takes one
// byte per clock cycle when the output side keeps up: each byte is held in
// an input register and decoded by the next-state logic into a result
// register, from which the result is presented on the master stream.
// Bytes such as size lines and chunk trailers produce no result. The body
// limit is set through the APB register at byte address 0 and should only
// be changed while the stream is idle.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] msg_start
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import chbd_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_start_q;
  logic                 advance;

  ctrl_t                ctrl_q, ctrl_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic [31:0]          count_q, count_d;

  logic                 emit;
  logic [7:0]           res_byte;
  kind_e                res_kind;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  kind_e                out_kind_q;
  logic [31:0]          max_body_size;

  chbd_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .max_body_size_o (max_body_size)
  );

  // The held byte is decoded whenever the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  chbd_step #(
    .SizeBits (SIZE_BITS)
  ) u_step (
    .data_byte_i     (in_byte_q),
    .msg_start_i     (in_start_q),
    .ctrl_i          (ctrl_q),
    .acc_i           (acc_q),
    .rem_i           (rem_q),
    .count_i         (count_q),
    .max_body_size_i (max_body_size),
    .ctrl_o          (ctrl_d),
    .acc_o           (acc_d),
    .rem_o           (rem_d),
    .count_o         (count_d),
    .emit_o          (emit),
    .out_byte_o      (res_byte),
    .kind_o          (res_kind)
  );

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '{phase: PH_SIZE, digits_stopped: 1'b0, cr_seen: 1'b0, skip_count: 2'd0};
      acc_q   <= '0;
      rem_q   <= '0;
      count_q <= '0;
    end else if (advance) begin
      ctrl_q  <= ctrl_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

[rtl/core/chbd_cfg.sv]
module chbd_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] max_body_size_o
);
  import chbd_pkg::*;

  logic [31:0] max_body_size_q;
  logic [31:0] max_body_size_d;
  reg_e        reg_sel;

  assign reg_sel = reg_e'(paddr[2]);
  assign pready  = 1'b1;

  // Register write on the access cycle.
  always_comb begin
    max_body_size_d = max_body_size_q;
    if (psel && penable && pwrite && reg_sel == REG_MAX_BODY_SIZE) begin
      max_body_size_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_size_q <= MaxBodySizeRst;
    end else begin
      max_body_size_q <= max_body_size_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      REG_MAX_BODY_SIZE: prdata = max_body_size_q;
      default:           prdata = 32'd0;
    endcase
  end

  assign max_body_size_o = max_body_size_q;

endmodule

[rtl/core/chbd_step.sv]
module chbd_step #(
  parameter int SizeBits = 32
) (
  input  logic [7:0]          data_byte_i,
  input  logic                msg_start_i,
  input  chbd_pkg::ctrl_t     ctrl_i,
  input  logic [SizeBits-1:0] acc_i,
  input  logic [SizeBits-1:0] rem_i,
  input  logic [31:0]         count_i,
  input  logic [31:0]         max_body_size_i,
  output chbd_pkg::ctrl_t     ctrl_o,
  output logic [SizeBits-1:0] acc_o,
  output logic [SizeBits-1:0] rem_o,
  output logic [31:0]         count_o,
  output logic                emit_o,
  output logic [7:0]          out_byte_o,
  output chbd_pkg::kind_e     kind_o
);
  import chbd_pkg::*;

  ctrl_t               ctrl_s;
  logic [SizeBits-1:0] acc_s;
  logic [SizeBits-1:0] rem_s;
  logic [31:0]         count_s;
  hex_t                hex;

  assign hex = hex_value(data_byte_i);

  // A start mark clears the decoder before the byte is handled.
  always_comb begin
    if (msg_start_i) begin
      ctrl_s  = '{phase: PH_SIZE, digits_stopped: 1'b0, cr_seen: 1'b0, skip_count: 2'd0};
      acc_s   = '0;
      rem_s   = '0;
      count_s = '0;
    end else begin
      ctrl_s  = ctrl_i;
      acc_s   = acc_i;
      rem_s   = rem_i;
      count_s = count_i;
    end
  end

  // One byte of the decoder.
  always_comb begin
    ctrl_o     = ctrl_s;
    acc_o      = acc_s;
    rem_o      = rem_s;
    count_o    = count_s;
    emit_o     = 1'b0;
    out_byte_o = 8'd0;
    kind_o     = KIND_DATA;
    unique case (ctrl_s.phase)
      PH_SIZE: begin
        if (ctrl_s.cr_seen && data_byte_i == ChrLf) begin
          if (acc_s == '0) begin
            ctrl_o.phase = PH_DONE;
            emit_o       = 1'b1;
            kind_o       = KIND_COMPLETE;
          end else begin
            rem_o        = acc_s;
            ctrl_o.phase = PH_DATA;
          end
        end else begin
          ctrl_o.cr_seen = (data_byte_i == ChrCr);
          if (!hex.valid) begin
            ctrl_o.digits_stopped = 1'b1;
          end else if (!ctrl_s.digits_stopped) begin
            if (acc_s[SizeBits-1 -: 4] != 4'd0) begin
              ctrl_o.phase = PH_DONE;
              emit_o       = 1'b1;
              kind_o       = KIND_OVERFLOW;
            end else begin
              acc_o = {acc_s[SizeBits-5:0], hex.value};
            end
          end
        end
      end
      PH_DATA: begin
        if (count_s >= max_body_size_i) begin
          ctrl_o.phase = PH_DONE;
          emit_o       = 1'b1;
          kind_o       = KIND_TOO_LARGE;
        end else begin
          count_o    = count_s + 32'd1;
          rem_o      = rem_s - SizeBits'(1);
          emit_o     = 1'b1;
          out_byte_o = data_byte_i;
          if (rem_s == SizeBits'(1)) begin
            ctrl_o.phase      = PH_SKIP;
            ctrl_o.skip_count = TrailerLen;
          end
        end
      end
      PH_SKIP: begin
        // Trailer bytes are dropped unchecked.
        if (ctrl_s.skip_count <= 2'd1) begin
          ctrl_o.skip_count     = 2'd0;
          ctrl_o.phase          = PH_SIZE;
          ctrl_o.digits_stopped = 1'b0;
          ctrl_o.cr_seen        = 1'b0;
          acc_o                 = '0;
        end else begin
          ctrl_o.skip_count = ctrl_s.skip_count - 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
